@@ sv/rtu_frame_receiver_unit_macros.svh @@
// Assertion macros for the frame receiver checker.
`ifndef RTU_FRAME_RECEIVER_UNIT_MACROS_SVH
`define RTU_FRAME_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define RTU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rtu check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define RTU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rtu check failed");

`endif

@@ sv/rtu_pkg.sv @@
// Shared types, codes and the CRC-16 byte update for the frame receiver.
package rtu_pkg;

    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_ARM  = 2'd2;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SHORT   = 2'd1;
    localparam logic [1:0] ST_CRC_ERR = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    localparam logic [1:0] REG_LISTEN_MODE = 2'd0;
    localparam logic [1:0] REG_BYTE_GAP    = 2'd1;
    localparam logic [1:0] REG_FRAME_GAP   = 2'd2;
    localparam logic [1:0] REG_RESPONSE    = 2'd3;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_SEED = 16'hFFFF;

    localparam logic [15:0] BYTE_GAP_RST  = 16'd2604;
    localparam logic [15:0] FRAME_GAP_RST = 16'd4686;
    localparam logic [23:0] RESPONSE_RST  = 24'd1000000;

    typedef struct packed {
        logic        listen_mode;
        logic [15:0] byte_gap_ticks;
        logic [15:0] frame_gap_ticks;
        logic [23:0] response_ticks;
    } t_cfg;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [1:0] status;
        logic [7:0] address;
        logic [7:0] pdu_length;
        logic       last;
    } t_res;

    // Up to two results produced by one item.
    typedef struct packed {
        logic [1:0] count;
        t_res       res0;
        t_res       res1;
    } t_push;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ sv/rtu_in_if.sv @@
// Input channel: one received byte, tick or arm request per transfer.
interface rtu_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

@@ sv/rtu_out_if.sv @@
// Output channel: one frame data byte or frame end report per transfer.
interface rtu_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    logic [1:0] status;
    logic [7:0] address;
    logic [7:0] pdu_length;
    logic       last;

    modport source (output valid, output kind, output data_byte, output status,
                    output address, output pdu_length, output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input status,
                    input address, input pdu_length, input last, output ready);
endinterface

@@ sv/rtu_core.sv @@
// Frame state, silence counters, CRC check and result assembly.
module rtu_core
    import rtu_pkg::*;
#(
    parameter int FRAME_CAPACITY = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output t_push      o_push
);

    localparam int CNT_W = $clog2(FRAME_CAPACITY + 1);

    logic [7:0]       r_delay0, r_delay1, n_delay0, n_delay1;
    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_crc, n_crc;
    logic [15:0]      r_gap, n_gap;
    logic [23:0]      r_wait, n_wait;
    logic             r_open, n_open;
    logic             r_idle, n_idle;
    logic             r_armed, n_armed;
    logic [7:0]       r_addr, n_addr;

    function automatic t_res end_report(input logic [CNT_W-1:0] cnt, input logic [15:0] crc,
                                        input logic [7:0] lo, input logic [7:0] hi,
                                        input logic [7:0] addr);
        t_res r;
        logic [CNT_W-1:0] len;
        r = '0;
        len = cnt - CNT_W'(3);
        r.kind = KIND_END;
        r.address = addr;
        if (cnt < CNT_W'(4)) begin
            r.status = ST_SHORT;
        end else begin
            r.status = ({hi, lo} == crc) ? ST_OK : ST_CRC_ERR;
            r.pdu_length = 8'(len);
        end
        return r;
    endfunction

    always_comb begin
        logic             start, emit, ended;
        logic [CNT_W-1:0] count0, count1;
        logic [15:0]      crc0, crc1, gap1;
        logic [23:0]      wait1;
        t_res             slot0, slot1;
        logic [1:0]       cnt;

        n_delay0 = r_delay0;
        n_delay1 = r_delay1;
        n_count  = r_count;
        n_crc    = r_crc;
        n_gap    = r_gap;
        n_wait   = r_wait;
        n_open   = r_open;
        n_idle   = r_idle;
        n_armed  = r_armed;
        n_addr   = r_addr;
        slot0    = '0;
        slot1    = '0;
        cnt      = 2'd0;
        start    = 1'b0;
        emit     = 1'b0;
        ended    = 1'b0;
        count0   = r_count;
        count1   = r_count;
        crc0     = r_crc;
        crc1     = r_crc;
        gap1     = r_gap;
        wait1    = r_wait;

        case (i_operation)
            OP_BYTE: begin
                start  = !r_open && (i_cfg.listen_mode || r_idle);
                count0 = start ? '0 : r_count;
                crc0   = start ? CRC_SEED : r_crc;
                if (start) begin
                    n_addr  = i_rx_byte;
                    n_armed = 1'b0;
                end
                n_idle = 1'b0;
                n_gap  = '0;
                if (r_open || start) begin
                    n_open = 1'b1;
                    // two newest bytes are held back as candidate CRC
                    emit = count0 >= CNT_W'(2);
                    crc1 = crc0;
                    if (emit) begin
                        slot0.kind      = KIND_DATA;
                        slot0.data_byte = r_delay0;
                        crc1            = crc_fold(crc0, r_delay0);
                        cnt             = 2'd1;
                    end
                    n_delay0 = r_delay1;
                    n_delay1 = i_rx_byte;
                    count1   = count0 + CNT_W'(1);
                    n_count  = count1;
                    n_crc    = crc1;
                    if (count1 >= CNT_W'(FRAME_CAPACITY)) begin
                        if (emit) begin
                            slot1 = end_report(count1, crc1, r_delay1, i_rx_byte, n_addr);
                            cnt   = 2'd2;
                        end else begin
                            slot0 = end_report(count1, crc1, r_delay1, i_rx_byte, n_addr);
                            cnt   = 2'd1;
                        end
                        n_open  = 1'b0;
                        n_count = '0;
                        n_crc   = CRC_SEED;
                    end
                end
            end
            OP_TICK: begin
                gap1   = (r_gap != 16'hFFFF) ? r_gap + 16'd1 : r_gap;
                wait1  = (r_wait != 24'hFFFFFF) ? r_wait + 24'd1 : r_wait;
                n_gap  = gap1;
                n_wait = wait1;
                ended  = r_open && (gap1 >= i_cfg.byte_gap_ticks);
                if (ended) begin
                    slot0   = end_report(r_count, r_crc, r_delay0, r_delay1, r_addr);
                    cnt     = 2'd1;
                    n_open  = 1'b0;
                    n_count = '0;
                    n_crc   = CRC_SEED;
                end
                if (gap1 >= i_cfg.frame_gap_ticks) begin
                    n_idle = 1'b1;
                end
                if (r_armed && !(r_open && !ended) && wait1 >= i_cfg.response_ticks) begin
                    n_armed = 1'b0;
                    if (ended) begin
                        slot1.kind   = KIND_END;
                        slot1.status = ST_TIMEOUT;
                        cnt          = 2'd2;
                    end else begin
                        slot0.kind   = KIND_END;
                        slot0.status = ST_TIMEOUT;
                        cnt          = 2'd1;
                    end
                end
            end
            OP_ARM: begin
                if (i_cfg.listen_mode && !r_open) begin
                    n_armed = 1'b1;
                    n_wait  = '0;
                end
            end
            default: begin
            end
        endcase

        if (cnt == 2'd2) begin
            slot1.last = 1'b1;
        end else if (cnt == 2'd1) begin
            slot0.last = 1'b1;
        end

        o_push.count = cnt;
        o_push.res0  = slot0;
        o_push.res1  = slot1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay0 <= '0;
            r_delay1 <= '0;
            r_count  <= '0;
            r_crc    <= CRC_SEED;
            r_gap    <= '0;
            r_wait   <= '0;
            r_open   <= 1'b0;
            r_idle   <= 1'b0;
            r_armed  <= 1'b0;
            r_addr   <= '0;
        end else if (i_fire) begin
            r_delay0 <= n_delay0;
            r_delay1 <= n_delay1;
            r_count  <= n_count;
            r_crc    <= n_crc;
            r_gap    <= n_gap;
            r_wait   <= n_wait;
            r_open   <= n_open;
            r_idle   <= n_idle;
            r_armed  <= n_armed;
            r_addr   <= n_addr;
        end
    end

endmodule

@@ sv/rtu_rfifo.sv @@
// Four-entry result queue: up to two in a cycle, one out when ready.
module rtu_rfifo
    import rtu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push_en,
    input  t_push      i_push,
    output logic [2:0] o_space,
    output logic       o_valid,
    input  logic       i_ready,
    output t_res       o_res
);

    localparam int DEPTH = 4;

    t_res       r_q [DEPTH];
    logic [1:0] r_wptr, r_rptr;
    logic [2:0] r_count;
    logic       pop;
    logic [1:0] push_n;

    assign pop     = (r_count != 3'd0) && i_ready;
    assign push_n  = i_push_en ? i_push.count : 2'd0;
    assign o_space = 3'(DEPTH) - r_count;
    assign o_valid = r_count != 3'd0;
    assign o_res   = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_q[r_wptr] <= i_push.res0;
        end
        if (push_n == 2'd2) begin
            r_q[r_wptr + 2'd1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + push_n;
            r_rptr  <= r_rptr + {1'b0, pop};
            r_count <= r_count + {1'b0, push_n} - {2'b00, pop};
        end
    end

endmodule

@@ sv/rtu_frame_receiver_unit.sv @@
// Path: an input transfer lands in the input register; the edge on which the queue has room for
// all its results updates the frame state and queues them, offered right after that edge.
// Throughput: one input item per clock while the queue has room; one result per clock while the
// reader is ready, so an item with two results (data byte plus end report) takes two output
// transfers of a 4-entry queue.
// Reset: synchronous, active low; frame state, counters, pointers and configuration registers
// return to their defaults at once, with no clearing pass; queue storage and held input are not.
module rtu_frame_receiver_unit
    import rtu_pkg::*;
#(
    parameter int FRAME_CAPACITY = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    rtu_in_if.sink      i_in,
    rtu_out_if.source   o_out
);

    // Configuration registers, to be written only while the block is quiet; the block does not enforce it.
    t_cfg       r_cfg;
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    // Input register in front of the single-pass core.
    logic       r_in_valid;
    logic [1:0] r_in_op;
    logic [7:0] r_in_byte;

    t_push      push;
    logic [2:0] space;
    logic       fire;
    logic       in_xfer;
    t_res       res;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.listen_mode     <= 1'b0;
            r_cfg.byte_gap_ticks  <= BYTE_GAP_RST;
            r_cfg.frame_gap_ticks <= FRAME_GAP_RST;
            r_cfg.response_ticks  <= RESPONSE_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_LISTEN_MODE: r_cfg.listen_mode     <= pwdata[0];
                REG_BYTE_GAP:    r_cfg.byte_gap_ticks  <= pwdata[15:0];
                REG_FRAME_GAP:   r_cfg.frame_gap_ticks <= pwdata[15:0];
                REG_RESPONSE:    r_cfg.response_ticks  <= pwdata[23:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_LISTEN_MODE: prdata = {31'd0, r_cfg.listen_mode};
            REG_BYTE_GAP:    prdata = {16'd0, r_cfg.byte_gap_ticks};
            REG_FRAME_GAP:   prdata = {16'd0, r_cfg.frame_gap_ticks};
            REG_RESPONSE:    prdata = {8'd0, r_cfg.response_ticks};
            default:         prdata = '0;
        endcase
    end

    // The held item is processed once the queue has room for all its results;
    // the input register refills in the same cycle.
    assign fire       = r_in_valid && (space >= {1'b0, push.count});
    assign i_in.ready = !r_in_valid || fire;
    assign in_xfer    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_op   <= i_in.operation;
            r_in_byte <= i_in.rx_byte;
        end
    end

    rtu_core #(
        .FRAME_CAPACITY(FRAME_CAPACITY)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_operation(r_in_op),
        .i_rx_byte  (r_in_byte),
        .i_cfg      (r_cfg),
        .o_push     (push)
    );

    rtu_rfifo u_rfifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_en(fire),
        .i_push   (push),
        .o_space  (space),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_res    (res)
    );

    assign o_out.kind       = res.kind;
    assign o_out.data_byte  = res.data_byte;
    assign o_out.status     = res.status;
    assign o_out.address    = res.address;
    assign o_out.pdu_length = res.pdu_length;
    assign o_out.last       = res.last;

endmodule

@@ sv/rtu_frame_receiver_unit_chk.sv @@
// Port-level checker for the frame receiver, bound to the top level.
`include "rtu_frame_receiver_unit_macros.svh"

module rtu_frame_receiver_unit_chk
    import rtu_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_kind,
    input logic [7:0] i_out_data_byte,
    input logic [1:0] i_out_status,
    input logic [7:0] i_out_address,
    input logic [7:0] i_out_pdu_length,
    input logic       i_out_last
);

    // A stalled result keeps its contents.
    `RTU_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable({i_out_kind, i_out_data_byte, i_out_status, i_out_address, i_out_pdu_length, i_out_last}))

    // Data transfers carry only the byte and the last flag.
    `RTU_ASSERT_NOW(a_data_clean, i_out_valid && i_out_kind == KIND_DATA, i_out_status == ST_OK && i_out_address == 8'd0 && i_out_pdu_length == 8'd0)

    // A timeout report names no frame.
    `RTU_ASSERT_NOW(a_timeout_clean, i_out_valid && i_out_kind == KIND_END && i_out_status == ST_TIMEOUT, i_out_address == 8'd0 && i_out_pdu_length == 8'd0 && i_out_data_byte == 8'd0)

    // Short frames report no PDU; every end report must be last.
    `RTU_ASSERT_NOW(a_end_report, i_out_valid && i_out_kind == KIND_END, i_out_last && (i_out_status != ST_SHORT || i_out_pdu_length == 8'd0))

endmodule

bind rtu_frame_receiver_unit rtu_frame_receiver_unit_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_kind      (o_out.kind),
    .i_out_data_byte (o_out.data_byte),
    .i_out_status    (o_out.status),
    .i_out_address   (o_out.address),
    .i_out_pdu_length(o_out.pdu_length),
    .i_out_last      (o_out.last)
);
